/* src/chss_pkg.sv */
`default_nettype none

package chss_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 31;

  // Fixed port widths
  localparam int PORT_W = 31;
  localparam int CNT_W  = 7;

  // Microprogram counter width
  localparam int PC_W = 5;

  // Datapath operations
  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_ACCEPT   = 4'd1;
  localparam logic [3:0] OP_DIFF     = 4'd2;
  localparam logic [3:0] OP_MUL1     = 4'd3;
  localparam logic [3:0] OP_MUL2     = 4'd4;
  localparam logic [3:0] OP_POP      = 4'd5;
  localparam logic [3:0] OP_LOADU    = 4'd6;
  localparam logic [3:0] OP_PUSH     = 4'd7;
  localparam logic [3:0] OP_SAVE_L   = 4'd8;
  localparam logic [3:0] OP_LOAD_OUT = 4'd9;
  localparam logic [3:0] OP_CLEAR    = 4'd10;

  // Jump conditions
  localparam logic [3:0] C_NEXT     = 4'd0;
  localparam logic [3:0] C_ALWAYS   = 4'd1;
  localparam logic [3:0] C_NO_REQ   = 4'd2;
  localparam logic [3:0] C_SKIP     = 4'd3;
  localparam logic [3:0] C_NO_SCAN  = 4'd4;
  localparam logic [3:0] C_LEFT     = 4'd5;
  localparam logic [3:0] C_NOT_FIN  = 4'd6;
  localparam logic [3:0] C_NO_CLOSE = 4'd7;
  localparam logic [3:0] C_LT2      = 4'd8;
  localparam logic [3:0] C_DONE     = 4'd9;
  localparam logic [3:0] C_OUT_BUSY = 4'd10;

  // Determinant operand triples
  localparam logic [1:0] DS_P = 2'd0;  // (under-top, top, new point)
  localparam logic [1:0] DS_F = 2'd1;  // (under-top, top, first)
  localparam logic [1:0] DS_L = 2'd2;  // (saved top, first, second)

  // Program labels
  localparam logic [PC_W-1:0] S_IDLE = PC_W'(0);
  localparam logic [PC_W-1:0] S_SCAN = PC_W'(2);
  localparam logic [PC_W-1:0] S_PUSH = PC_W'(8);
  localparam logic [PC_W-1:0] S_TAIL = PC_W'(9);
  localparam logic [PC_W-1:0] S_EMIT = PC_W'(21);
  localparam logic [PC_W-1:0] S_LOAD = PC_W'(22);
  localparam logic [PC_W-1:0] S_END  = PC_W'(24);

  typedef struct packed {
    logic [3:0]      op;
    logic [3:0]      cond;
    logic [PC_W-1:0] target;
    logic [1:0]      dsel;
    logic            rd_idx;   // stack read address: 1 = emit index, 0 = depth-3
  } ctl_word_t;

  // Orientation unit controls
  typedef struct packed {
    logic diff;
    logic mul_lo;
    logic mul_hi;
  } orient_ctl_t;

  function automatic ctl_word_t cw(input logic [3:0] op, input logic [3:0] cond,
                                   input logic [PC_W-1:0] target,
                                   input logic [1:0] dsel, input logic rd_idx);
    ctl_word_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    w.dsel   = dsel;
    w.rd_idx = rd_idx;
    return w;
  endfunction

  // Control store
  function automatic ctl_word_t ucode(input logic [PC_W-1:0] pc);
    ctl_word_t w;
    unique case (pc)
      // take a point
      PC_W'(0):  w = cw(OP_ACCEPT,   C_NO_REQ,   S_IDLE, DS_P, 1'b0);
      PC_W'(1):  w = cw(OP_NONE,     C_SKIP,     S_TAIL, DS_P, 1'b0);
      // pop loop
      PC_W'(2):  w = cw(OP_DIFF,     C_NO_SCAN,  S_PUSH, DS_P, 1'b0);
      PC_W'(3):  w = cw(OP_MUL1,     C_NEXT,     S_IDLE, DS_P, 1'b0);
      PC_W'(4):  w = cw(OP_MUL2,     C_NEXT,     S_IDLE, DS_P, 1'b0);
      PC_W'(5):  w = cw(OP_NONE,     C_LEFT,     S_PUSH, DS_P, 1'b0);
      PC_W'(6):  w = cw(OP_POP,      C_NEXT,     S_IDLE, DS_P, 1'b0);
      PC_W'(7):  w = cw(OP_LOADU,    C_ALWAYS,   S_SCAN, DS_P, 1'b0);
      PC_W'(8):  w = cw(OP_PUSH,     C_NEXT,     S_IDLE, DS_P, 1'b0);
      PC_W'(9):  w = cw(OP_NONE,     C_NOT_FIN,  S_IDLE, DS_P, 1'b0);
      // closing checks
      PC_W'(10): w = cw(OP_SAVE_L,   C_NO_CLOSE, S_EMIT, DS_F, 1'b0);
      PC_W'(11): w = cw(OP_DIFF,     C_LT2,      S_EMIT, DS_F, 1'b0);
      PC_W'(12): w = cw(OP_MUL1,     C_NEXT,     S_IDLE, DS_F, 1'b0);
      PC_W'(13): w = cw(OP_MUL2,     C_NEXT,     S_IDLE, DS_F, 1'b0);
      PC_W'(14): w = cw(OP_NONE,     C_LEFT,     S_EMIT, DS_F, 1'b0);
      PC_W'(15): w = cw(OP_POP,      C_NEXT,     S_IDLE, DS_F, 1'b0);
      PC_W'(16): w = cw(OP_DIFF,     C_LT2,      S_EMIT, DS_L, 1'b0);
      PC_W'(17): w = cw(OP_MUL1,     C_NEXT,     S_IDLE, DS_L, 1'b0);
      PC_W'(18): w = cw(OP_MUL2,     C_NEXT,     S_IDLE, DS_L, 1'b0);
      PC_W'(19): w = cw(OP_NONE,     C_LEFT,     S_EMIT, DS_L, 1'b0);
      PC_W'(20): w = cw(OP_POP,      C_NEXT,     S_IDLE, DS_L, 1'b0);
      // emit bottom to top
      PC_W'(21): w = cw(OP_NONE,     C_DONE,     S_END,  DS_P, 1'b1);
      PC_W'(22): w = cw(OP_LOAD_OUT, C_OUT_BUSY, S_LOAD, DS_P, 1'b1);
      PC_W'(23): w = cw(OP_NONE,     C_ALWAYS,   S_EMIT, DS_P, 1'b1);
      PC_W'(24): w = cw(OP_CLEAR,    C_ALWAYS,   S_IDLE, DS_P, 1'b0);
      default:   w = cw(OP_NONE,     C_ALWAYS,   S_IDLE, DS_P, 1'b0);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* src/chss_orient.sv */
`default_nettype none

// Orientation test: (bx-ax)*(cy-ay) > (by-ay)*(cx-ax), one shared multiplier.
module chss_orient #(
  parameter int COORD_BITS = chss_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire chss_pkg::orient_ctl_t        ctl,
  input  wire logic signed [COORD_BITS-1:0] ax,
  input  wire logic signed [COORD_BITS-1:0] ay,
  input  wire logic signed [COORD_BITS-1:0] bx,
  input  wire logic signed [COORD_BITS-1:0] by,
  input  wire logic signed [COORD_BITS-1:0] cx,
  input  wire logic signed [COORD_BITS-1:0] cy,
  output logic                              left
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] d1x, d1y, d2x, d2y;
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] lhs, rhs;

  // Differences registered ahead of the multiplier
  always_ff @(posedge clk) begin
    if (ctl.diff) begin
      d1x <= DW'(bx) - DW'(ax);
      d1y <= DW'(by) - DW'(ay);
      d2x <= DW'(cx) - DW'(ax);
      d2y <= DW'(cy) - DW'(ay);
    end
  end

  // Shared multiplier, one product per step
  assign mul_a = ctl.mul_hi ? d1y : d1x;
  assign mul_b = ctl.mul_hi ? d2x : d2y;
  assign prod  = PW'(mul_a) * PW'(mul_b);

  always_ff @(posedge clk) begin
    if (ctl.mul_lo) begin
      lhs <= prod;
    end
    if (ctl.mul_hi) begin
      rhs <= prod;
    end
  end

  assign left = lhs > rhs;

endmodule

`default_nettype wire

/* src/convex_hull_stack_scan_core.sv */
`default_nettype none

// Graham-scan hull over points that arrive already in angular order, one request per point.
// final_point closes the set: the hull comes out bottom to top, one request per hull point,
// each carrying the hull size, a last mark on the top point and the overflow flag; then the
// block starts a fresh set. Points past MAX_POINTS are dropped and flagged. A small
// microprogram drives one shared multiplier and a stack RAM with one write port and one
// registered read port. Each pop in the scan takes a difference, two multiplies, a compare,
// the pop and a RAM refill of the under-top entry. A final point runs closing checks before
// the hull points are emitted; a stalled output holds emission. Coordinates come out in their
// low COORD_BITS bits.
module convex_hull_stack_scan_core #(
  parameter int MAX_POINTS = chss_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = chss_pkg::COORD_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [chss_pkg::PORT_W-1:0]     px,
  input  wire logic [chss_pkg::PORT_W-1:0]     py,
  input  wire logic                            final_point,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [chss_pkg::PORT_W-1:0]          hull_x,
  output logic [chss_pkg::PORT_W-1:0]          hull_y,
  output logic [chss_pkg::CNT_W-1:0]           hull_count,
  output logic                                 last_of_run,
  output logic                                 overflowed
);

  localparam int DEPTH_W = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W  = $clog2(MAX_POINTS);
  localparam int PT_W    = 2 * COORD_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // Sequencer
  logic [chss_pkg::PC_W-1:0] pc, pc_next;
  chss_pkg::ctl_word_t       cw;
  logic                      jump;

  // Datapath state
  point_t               pnt, tp, un, lst, first, second;
  logic                 fin, take, scan;
  logic [DEPTH_W-1:0]   depth, seen, idx;
  logic                 ovf;
  logic [PT_W-1:0]      stack_mem [MAX_POINTS];
  logic [PT_W-1:0]      rdata;
  logic [ADDR_W-1:0]    raddr;
  logic [DEPTH_W-1:0]   depth_m3;

  // Output register
  logic [COORD_BITS-1:0] out_x, out_y;
  logic [DEPTH_W-1:0]    out_cnt;
  logic                  out_last, out_ovf;

  logic                  in_fire, out_busy, left;
  point_t                in_pt, op_a, op_b, op_c;
  chss_pkg::orient_ctl_t octl;

  assign cw       = chss_pkg::ucode(pc);
  assign in_ready = cw.op == chss_pkg::OP_ACCEPT;
  assign in_fire  = in_valid && in_ready;
  assign out_busy = out_valid && !out_ready;
  assign in_pt.x  = px[COORD_BITS-1:0];
  assign in_pt.y  = py[COORD_BITS-1:0];

  // Jump condition
  always_comb begin
    unique case (cw.cond)
      chss_pkg::C_NEXT:     jump = 1'b0;
      chss_pkg::C_ALWAYS:   jump = 1'b1;
      chss_pkg::C_NO_REQ:   jump = !in_fire;
      chss_pkg::C_SKIP:     jump = !take;
      chss_pkg::C_NO_SCAN:  jump = !scan || (depth < DEPTH_W'(2));
      chss_pkg::C_LEFT:     jump = left;
      chss_pkg::C_NOT_FIN:  jump = !fin;
      chss_pkg::C_NO_CLOSE: jump = !((seen >= DEPTH_W'(2)) && (depth >= DEPTH_W'(1)));
      chss_pkg::C_LT2:      jump = depth < DEPTH_W'(2);
      chss_pkg::C_DONE:     jump = idx == depth;
      chss_pkg::C_OUT_BUSY: jump = out_busy;
      default:              jump = 1'b1;
    endcase
  end

  assign pc_next = jump ? cw.target : pc + chss_pkg::PC_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= chss_pkg::S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // Determinant operands
  always_comb begin
    unique case (cw.dsel)
      chss_pkg::DS_P: begin op_a = un;  op_b = tp;    op_c = pnt;    end
      chss_pkg::DS_F: begin op_a = un;  op_b = tp;    op_c = first;  end
      chss_pkg::DS_L: begin op_a = lst; op_b = first; op_c = second; end
      default:        begin op_a = un;  op_b = tp;    op_c = pnt;    end
    endcase
  end

  assign octl.diff   = cw.op == chss_pkg::OP_DIFF;
  assign octl.mul_lo = cw.op == chss_pkg::OP_MUL1;
  assign octl.mul_hi = cw.op == chss_pkg::OP_MUL2;

  chss_orient #(
    .COORD_BITS(COORD_BITS)
  ) u_orient (
    .clk  (clk),
    .ctl  (octl),
    .ax   (op_a.x),
    .ay   (op_a.y),
    .bx   (op_b.x),
    .by   (op_b.y),
    .cx   (op_c.x),
    .cy   (op_c.y),
    .left (left)
  );

  // Stack RAM: one write, one registered read
  assign depth_m3 = depth - DEPTH_W'(3);
  assign raddr    = cw.rd_idx ? idx[ADDR_W-1:0] : depth_m3[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cw.op == chss_pkg::OP_PUSH) begin
      stack_mem[depth[ADDR_W-1:0]] <= pnt;
    end
    rdata <= stack_mem[raddr];
  end

  // Control counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
      seen  <= '0;
      ovf   <= 1'b0;
    end else begin
      unique case (cw.op)
        chss_pkg::OP_ACCEPT: begin
          if (in_fire) begin
            if (seen < DEPTH_W'(MAX_POINTS)) begin
              seen <= seen + DEPTH_W'(1);
            end else begin
              ovf <= 1'b1;
            end
          end
        end
        chss_pkg::OP_POP:   depth <= depth - DEPTH_W'(1);
        chss_pkg::OP_PUSH:  depth <= depth + DEPTH_W'(1);
        chss_pkg::OP_CLEAR: begin
          depth <= '0;
          seen  <= '0;
          ovf   <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Point registers and top-of-stack cache
  always_ff @(posedge clk) begin
    unique case (cw.op)
      chss_pkg::OP_ACCEPT: begin
        if (in_fire) begin
          pnt  <= in_pt;
          fin  <= final_point;
          take <= seen < DEPTH_W'(MAX_POINTS);
          scan <= seen >= DEPTH_W'(2);
          if (seen == DEPTH_W'(0)) begin
            first <= in_pt;
          end
          if (seen == DEPTH_W'(1)) begin
            second <= in_pt;
          end
        end
      end
      chss_pkg::OP_POP:    tp <= un;
      chss_pkg::OP_LOADU:  un <= rdata;
      chss_pkg::OP_PUSH: begin
        un <= tp;
        tp <= pnt;
      end
      chss_pkg::OP_SAVE_L: begin
        lst <= tp;
        idx <= '0;
      end
      chss_pkg::OP_LOAD_OUT: begin
        if (!out_busy) begin
          idx <= idx + DEPTH_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.op == chss_pkg::OP_LOAD_OUT && !out_busy) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.op == chss_pkg::OP_LOAD_OUT && !out_busy) begin
      out_x    <= rdata[PT_W-1:COORD_BITS];
      out_y    <= rdata[COORD_BITS-1:0];
      out_cnt  <= depth;
      out_last <= (idx + DEPTH_W'(1)) == depth;
      out_ovf  <= ovf;
    end
  end

  assign hull_x      = chss_pkg::PORT_W'(out_x);
  assign hull_y      = chss_pkg::PORT_W'(out_y);
  assign hull_count  = chss_pkg::CNT_W'(out_cnt);
  assign last_of_run = out_last;
  assign overflowed  = out_ovf;

  // Checks
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_W'(MAX_POINTS))
    else $error("hull stack depth beyond capacity");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (cw.op == chss_pkg::OP_PUSH) |-> (depth < DEPTH_W'(MAX_POINTS)))
    else $error("push onto a full hull stack");

  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    (cw.op == chss_pkg::OP_LOAD_OUT && !out_busy) |-> (idx < depth))
    else $error("emit index past stack depth");

endmodule

`default_nettype wire
